[hw/rtl/pcfd_pkg.sv]
// Shared widths and constants of the filtered-derivative PID controller.
package pcfd_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int OPB_W      = DATA_W + 1;
    localparam int PROD_W     = DATA_W + OPB_W;
    localparam int SUM_W      = DATA_W + 2;
    localparam int CNT_W      = $clog2(OPB_W + 1);
    localparam int DUTY_W     = 14;
    localparam int DUTY_FULL  = 8192;
    localparam int DUTY_DIV   = (100 << FRAC_W) / DUTY_FULL;
    localparam int DUTY_Q_W   = $clog2(DUTY_FULL);
    localparam int DUTY_R_W   = $clog2(DUTY_FULL * DUTY_DIV);
    localparam int DUTY_I_W   = $clog2(DUTY_Q_W);
    localparam int CFG_ADDR_W = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN  = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV_DCY  = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_MIN    = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_MAX    = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_MIN  = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_MAX  = 4'd7;

endpackage

[hw/rtl/pcfd_mul.sv]
// Bit-serial signed fixed-point multiplier with rounding and saturation.
module pcfd_mul import pcfd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [OPB_W-1:0]  i_b,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_prod
);

    logic [DATA_W-1:0]        r_a;
    logic [PROD_W:0]          r_p;
    logic                     r_neg;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_fin;
    logic                     r_done;
    logic signed [DATA_W-1:0] r_prod;

    logic [DATA_W-1:0]   w_amag;
    logic [OPB_W-1:0]    w_bmag;
    logic [DATA_W:0]     w_sum;
    logic [PROD_W:0]     w_rnd;
    logic [PROD_W-FRAC_W:0] w_q;
    logic [PROD_W-FRAC_W:0] w_lim;
    logic [PROD_W-FRAC_W:0] w_qs;

    assign w_amag = i_a[DATA_W-1] ? (~i_a + 1'b1) : i_a;
    assign w_bmag = i_b[OPB_W-1] ? (~i_b + 1'b1) : i_b;
    assign w_sum  = r_p[PROD_W:OPB_W] + {1'b0, (r_p[0] ? r_a : '0)};
    assign w_rnd  = {1'b0, r_p[PROD_W-1:0]} + ((PROD_W+1)'(1) << (FRAC_W - 1));
    assign w_q    = w_rnd[PROD_W:FRAC_W];
    assign w_lim  = r_neg ? ((PROD_W-FRAC_W+1)'(1) << (DATA_W - 1))
                          : (((PROD_W-FRAC_W+1)'(1) << (DATA_W - 1)) - 1'b1);
    assign w_qs   = (w_q > w_lim) ? w_lim : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(OPB_W);
                r_fin <= 1'b0;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_fin <= (r_cnt == CNT_W'(1));
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= w_amag;
            r_p   <= {{(DATA_W+1){1'b0}}, w_bmag};
            r_neg <= i_a[DATA_W-1] ^ i_b[OPB_W-1];
        end else if (r_cnt != '0) begin
            r_p <= {1'b0, w_sum, r_p[OPB_W-1:1]};
        end else if (r_fin) begin
            r_prod <= r_neg ? -$signed(w_qs[DATA_W-1:0]) : $signed(w_qs[DATA_W-1:0]);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

[hw/rtl/pcfd_duty.sv]
// Serial restoring divider that turns the drive value into a PWM duty count.
module pcfd_duty import pcfd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_done,
    output logic [DUTY_W-1:0]        o_duty
);

    logic [DUTY_R_W-1:0] r_rem;
    logic [DUTY_Q_W-1:0] r_q;
    logic [DUTY_I_W-1:0] r_idx;
    logic                r_run;
    logic                r_done;
    logic [DUTY_W-1:0]   r_duty;

    logic [DUTY_R_W-1:0] w_sub;
    logic                w_ge;

    assign w_sub = DUTY_R_W'(DUTY_DIV) << r_idx;
    assign w_ge  = (r_rem >= w_sub);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_value <= 0) begin
                    r_done <= 1'b1;
                end else if (i_value >= DATA_W'(DUTY_FULL * DUTY_DIV)) begin
                    r_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                end
            end else if (r_run && r_idx == '0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value[DUTY_R_W-1:0];
            r_q   <= '0;
            r_idx <= DUTY_I_W'(DUTY_Q_W - 1);
            if (i_value <= 0) begin
                r_duty <= '0;
            end else if (i_value >= DATA_W'(DUTY_FULL * DUTY_DIV)) begin
                r_duty <= DUTY_W'(DUTY_FULL);
            end
        end else if (r_run) begin
            if (w_ge) begin
                r_rem <= r_rem - w_sub;
            end
            r_q   <= {r_q[DUTY_Q_W-2:0], w_ge};
            r_idx <= r_idx - 1'b1;
            if (r_idx == '0) begin
                r_duty <= DUTY_W'({r_q[DUTY_Q_W-2:0], w_ge});
            end
        end
    end

    assign o_done = r_done;
    assign o_duty = r_duty;

endmodule

[hw/rtl/pid_controller_filtered_derivative.sv]
// PID controller with trapezoidal integrator and band-limited derivative: top level.
// Each input word (setpoint, measurement, signed Q15.16) yields one output word
// (clamped drive, PWM duty). Four bit-serial multipliers work in parallel, one
// operand bit per cycle, then a serial divider works out the duty from the drive.
// One word is in flight at a time; the next word is taken while a finished result
// still waits on the output.
module pid_controller_filtered_derivative import pcfd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_target,
    input  logic signed [DATA_W-1:0] i_sensed,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_drive_value,
    output logic [DUTY_W-1:0]        o_pwm_duty
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_COMB = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_DUTY = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((64'sd1 <<< (DATA_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] VMIN = -VMAX - 1;

    function automatic logic signed [DATA_W-1:0] sat(input logic signed [SUM_W-1:0] x);
        logic signed [DATA_W-1:0] v;
        if (x > VMAX) begin
            v = VMAX[DATA_W-1:0];
        end else if (x < VMIN) begin
            v = VMIN[DATA_W-1:0];
        end else begin
            v = x[DATA_W-1:0];
        end
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp(input logic signed [DATA_W-1:0] x,
                                                       input logic signed [DATA_W-1:0] lo,
                                                       input logic signed [DATA_W-1:0] hi);
        logic signed [DATA_W-1:0] v;
        if (x > hi) begin
            v = hi;
        end else if (x < lo) begin
            v = lo;
        end else begin
            v = x;
        end
        return v;
    endfunction

    logic signed [DATA_W-1:0] r_kp, r_ki, r_kd, r_dec, r_omin, r_omax, r_imin, r_imax;
    logic signed [DATA_W-1:0] r_integ_acc, r_last_err, r_deriv_acc, r_last_sensed;
    logic [2:0]               r_state;
    logic signed [DATA_W-1:0] r_tgt, r_meas, r_e, r_integ, r_d, r_o;
    logic signed [OPB_W-1:0]  r_s, r_dm;
    logic                     r_mstart, r_dstart;
    logic                     r_ovalid;
    logic signed [DATA_W-1:0] r_odrive;
    logic [DUTY_W-1:0]        r_oduty;

    logic [3:0]               w_mdone;
    logic signed [DATA_W-1:0] w_mp, w_mi, w_mdec, w_mkd;
    logic                     w_ddone;
    logic [DUTY_W-1:0]        w_duty;
    logic signed [DATA_W-1:0] w_e, w_integ, w_o;
    logic                     w_in_acc, w_out_acc, w_load;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_ovalid && !i_out_stall;
    assign w_load    = (r_state == S_OUT) && (!r_ovalid || !i_out_stall);
    assign w_e       = sat(SUM_W'(r_tgt) - SUM_W'(r_meas));
    assign w_integ   = clamp(sat(SUM_W'(r_integ_acc) + SUM_W'(w_mi)), r_imin, r_imax);
    assign w_o       = clamp(sat(SUM_W'(w_mp) + SUM_W'(r_integ) + SUM_W'(r_d)),
                             r_omin, r_omax);

    pcfd_mul u_mul_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart),
        .i_a(r_kp), .i_b(OPB_W'(r_e)), .o_done(w_mdone[0]), .o_prod(w_mp)
    );
    pcfd_mul u_mul_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart),
        .i_a(r_ki), .i_b(r_s), .o_done(w_mdone[1]), .o_prod(w_mi)
    );
    pcfd_mul u_mul_dec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart),
        .i_a(r_dec), .i_b(OPB_W'(r_deriv_acc)), .o_done(w_mdone[2]), .o_prod(w_mdec)
    );
    pcfd_mul u_mul_kd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart),
        .i_a(r_kd), .i_b(r_dm), .o_done(w_mdone[3]), .o_prod(w_mkd)
    );

    pcfd_duty u_duty (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_value(r_o), .o_done(w_ddone), .o_duty(w_duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= 32'sd131072;
            r_ki   <= 32'sd1147;
            r_kd   <= 32'sd655360;
            r_dec  <= 32'sd39322;
            r_omin <= -32'sd6553600;
            r_omax <= 32'sd6553600;
            r_imin <= -32'sd5570560;
            r_imax <= 32'sd5570560;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PROP_GAIN:  r_kp   <= i_cfg_data;
                REG_INTEG_GAIN: r_ki   <= i_cfg_data;
                REG_DERIV_GAIN: r_kd   <= i_cfg_data;
                REG_DERIV_DCY:  r_dec  <= i_cfg_data;
                REG_OUT_MIN:    r_omin <= i_cfg_data;
                REG_OUT_MAX:    r_omax <= i_cfg_data;
                REG_INTEG_MIN:  r_imin <= i_cfg_data;
                REG_INTEG_MAX:  r_imax <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mstart      <= 1'b0;
            r_dstart      <= 1'b0;
            r_ovalid      <= 1'b0;
            r_integ_acc   <= '0;
            r_last_err    <= '0;
            r_deriv_acc   <= '0;
            r_last_sensed <= '0;
        end else begin
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            r_ovalid <= w_load || (r_ovalid && !w_out_acc);
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_mstart <= 1'b1;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    if (&w_mdone) begin
                        r_state <= S_COMB;
                    end
                end
                S_COMB: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_integ_acc   <= r_integ;
                    r_deriv_acc   <= r_d;
                    r_last_err    <= r_e;
                    r_last_sensed <= r_meas;
                    r_dstart      <= 1'b1;
                    r_state       <= S_DUTY;
                end
                S_DUTY: begin
                    if (w_ddone) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_tgt  <= i_target;
            r_meas <= i_sensed;
        end
        if (r_state == S_PREP) begin
            r_e  <= w_e;
            r_s  <= OPB_W'(w_e) + OPB_W'(r_last_err);
            r_dm <= OPB_W'(r_meas) - OPB_W'(r_last_sensed);
        end
        if (r_state == S_COMB) begin
            r_integ <= w_integ;
            r_d     <= sat(SUM_W'(w_mdec) - SUM_W'(w_mkd));
        end
        if (r_state == S_SUM) begin
            r_o <= w_o;
        end
        if (w_load) begin
            r_odrive <= r_o;
            r_oduty  <= w_duty;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_drive_value = r_odrive;
    assign o_pwm_duty    = r_oduty;

`ifndef SYNTHESIS
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pwm_duty <= DUTY_W'(DUTY_FULL)))
        else $error("Duty count exceeds full scale.");
    a_neg_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_value <= 0) |-> (o_pwm_duty == '0))
        else $error("Non-positive drive gave a nonzero duty.");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (o_in_stall && r_state == S_PREP))
        else $error("Accepted word did not start the sequence.");
    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_mdone) |-> (&w_mdone))
        else $error("Multipliers finished out of step.");
`endif

endmodule

[dv/tb_pid_controller_filtered_derivative.sv]
// Self-checking testbench for the filtered-derivative PID controller with random flow control.
module tb_pid_controller_filtered_derivative;
    import pcfd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint VMAX = (64'sd1 <<< (DATA_W - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam int NUM_REGS = 8;

    typedef struct {
        logic signed [DATA_W-1:0] drive;
        logic [DUTY_W-1:0]        duty;
    } t_drive_word;

    class drive_predictor;
        logic signed [DATA_W-1:0] gains[NUM_REGS];
        longint integ_acc, last_error, deriv_acc, last_sensed;
        t_drive_word pending_drive[$];
        int errors;

        function new();
            gains[REG_PROP_GAIN]  = 32'sd131072;
            gains[REG_INTEG_GAIN] = 32'sd1147;
            gains[REG_DERIV_GAIN] = 32'sd655360;
            gains[REG_DERIV_DCY]  = 32'sd39322;
            gains[REG_OUT_MIN]    = -32'sd6553600;
            gains[REG_OUT_MAX]    = 32'sd6553600;
            gains[REG_INTEG_MIN]  = -32'sd5570560;
            gains[REG_INTEG_MAX]  = 32'sd5570560;
            integ_acc = 0;
            last_error = 0;
            deriv_acc = 0;
            last_sensed = 0;
            errors = 0;
        endfunction

        function void write_gain(logic [CFG_ADDR_W-1:0] idx, logic [DATA_W-1:0] val);
            if (idx < NUM_REGS) begin
                gains[idx] = val;
            end
        endfunction

        function longint sat(longint x);
            if (x > VMAX) return VMAX;
            if (x < VMIN) return VMIN;
            return x;
        endfunction

        function longint clamp_lim(longint x, longint lo, longint hi);
            if (x > hi) return hi;
            if (x < lo) return lo;
            return x;
        endfunction

        // Rounded fixed-point product, saturated to the data width.
        function longint fx_mul(longint a, longint b);
            logic [127:0] prod;
            logic [63:0] ua, ub;
            logic [127:0] lim;
            bit neg;
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            neg = (a < 0) != (b < 0);
            prod = 128'(ua) * 128'(ub);
            prod = (prod + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
            lim = neg ? 128'(VMAX) + 1 : 128'(VMAX);
            if (prod > lim) prod = lim;
            return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
        endfunction

        function void note_input(logic signed [DATA_W-1:0] target,
                                 logic signed [DATA_W-1:0] sensed);
            longint tgt, meas, e, p, integ, d, o, duty;
            t_drive_word w;
            tgt = target;
            meas = sensed;
            e = sat(tgt - meas);
            p = fx_mul(gains[REG_PROP_GAIN], e);
            integ = sat(integ_acc + fx_mul(gains[REG_INTEG_GAIN], e + last_error));
            integ = sat(clamp_lim(integ, gains[REG_INTEG_MIN], gains[REG_INTEG_MAX]));
            d = sat(fx_mul(gains[REG_DERIV_DCY], deriv_acc)
                    - fx_mul(gains[REG_DERIV_GAIN], meas - last_sensed));
            o = sat(p + integ + d);
            o = clamp_lim(o, gains[REG_OUT_MIN], gains[REG_OUT_MAX]);
            integ_acc = integ;
            deriv_acc = d;
            last_error = e;
            last_sensed = sat(meas);
            duty = 0;
            if (o > 0) begin
                duty = (o * DUTY_FULL) / (longint'(100) << FRAC_W);
                if (duty > DUTY_FULL) duty = DUTY_FULL;
            end
            w.drive = o[DATA_W-1:0];
            w.duty = duty[DUTY_W-1:0];
            pending_drive.push_back(w);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] drive, logic [DUTY_W-1:0] duty);
            t_drive_word w;
            if (pending_drive.size() == 0) begin
                $display("%0t: unexpected word drive=%0d duty=%0d", $time, drive, duty);
                errors++;
                return;
            end
            w = pending_drive.pop_front();
            if (drive !== w.drive) begin
                $display("%0t: drive_value expected %0d actual %0d", $time, w.drive, drive);
                errors++;
            end
            if (duty !== w.duty) begin
                $display("%0t: pwm_duty expected %0d actual %0d", $time, w.duty, duty);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]    i_cfg_addr = '0;
    logic [DATA_W-1:0]        i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_target = '0;
    logic signed [DATA_W-1:0] i_sensed = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_drive_value;
    logic [DUTY_W-1:0]        o_pwm_duty;

    drive_predictor pred = new();
    int burst_left = 0;
    int stall_mode = 0;
    int stall_span = 0;

    pid_controller_filtered_derivative dut (.*);

    always #4 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(20, 300);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 9) < 3);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 9) < 8);
            end
            default: begin
                i_out_stall <= stall_span[4];
            end
        endcase
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            pred.check_result(o_drive_value, o_pwm_duty);
        end
    end

    task automatic send_word(input logic [DATA_W-1:0] t, input logic [DATA_W-1:0] s);
        i_target <= t;
        i_sensed <= s;
        i_in_valid <= 1'b1;
        do @(negedge i_clk); while (o_in_stall);
        pred.note_input(t, s);
        @(posedge i_clk);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pred.pending_drive.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        pred.write_gain(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom_range(0, 400 << FRAC_W) - (200 << FRAC_W);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_gain();
        if ($urandom_range(0, 4) == 0) return rand_word();
        return $urandom_range(0, 16 << FRAC_W) - (8 << FRAC_W);
    endfunction

    task automatic program_set(input int kind);
        logic signed [DATA_W-1:0] a, b;
        case (kind)
            0: begin
                write_reg(REG_PROP_GAIN, 32'h7FFF_FFFF);
                write_reg(REG_INTEG_GAIN, 32'h7FFF_FFFF);
                write_reg(REG_DERIV_GAIN, 32'h7FFF_FFFF);
                write_reg(REG_DERIV_DCY, 32'h7FFF_FFFF);
                write_reg(REG_OUT_MIN, 32'h8000_0000);
                write_reg(REG_OUT_MAX, 32'h7FFF_FFFF);
                write_reg(REG_INTEG_MIN, 32'h8000_0000);
                write_reg(REG_INTEG_MAX, 32'h7FFF_FFFF);
            end
            1: begin
                write_reg(REG_PROP_GAIN, 32'h8000_0000);
                write_reg(REG_INTEG_GAIN, 32'h8000_0000);
                write_reg(REG_DERIV_GAIN, 32'h8000_0000);
                write_reg(REG_DERIV_DCY, 32'h8000_0000);
                write_reg(REG_OUT_MIN, 32'h7FFF_FFFF);
                write_reg(REG_OUT_MAX, 32'h8000_0000);
                write_reg(REG_INTEG_MIN, 32'h0010_0000);
                write_reg(REG_INTEG_MAX, -32'sh0010_0000);
            end
            default: begin
                write_reg(REG_PROP_GAIN, rand_gain());
                write_reg(REG_INTEG_GAIN, rand_gain());
                write_reg(REG_DERIV_GAIN, rand_gain());
                write_reg(REG_DERIV_DCY, $urandom_range(0, 1 << FRAC_W));
                a = rand_word();
                b = rand_word();
                if ($urandom_range(0, 3) != 0 && a > b) begin
                    write_reg(REG_OUT_MIN, b);
                    write_reg(REG_OUT_MAX, a);
                end else begin
                    write_reg(REG_OUT_MIN, a);
                    write_reg(REG_OUT_MAX, b);
                end
                a = rand_word();
                b = rand_word();
                write_reg(REG_INTEG_MIN, (a < b) ? a : b);
                write_reg(REG_INTEG_MAX, (a < b) ? b : a);
            end
        endcase
    endtask

    initial begin
        logic [DATA_W-1:0] dir_t[16];
        logic [DATA_W-1:0] dir_s[16];
        int sel;
        dir_t = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h0064_0000, 32'h0064_0000, 32'h0064_0000, 32'hFF9C_0000, 32'hFF9C_0000,
            32'h0001_0000, 32'h0000_8000, 32'h0000_0001, 32'h0032_0000, 32'h0,
            32'hFFFF_FFFF, 32'h0000_0320};
        dir_s = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
            32'h0032_0000, 32'hFFFF_FFFF, 32'h0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_t[k]) send_word(dir_t[k], dir_s[k]);
        drain();
        for (int k = NUM_REGS; k < (1 << CFG_ADDR_W); k++) begin
            write_reg(CFG_ADDR_W'(k), $urandom());
        end
        for (int ph = 0; ph < 8; ph++) begin
            program_set(ph);
            for (int k = 0; k < 160; k++) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    send_word($urandom(), $urandom());
                end else if (sel < 3) begin
                    send_word(rand_word(), rand_word());
                end else begin
                    send_word($urandom_range(0, 200 << FRAC_W) - (100 << FRAC_W),
                              $urandom_range(0, 200 << FRAC_W) - (100 << FRAC_W));
                end
            end
            drain();
        end
        if (pred.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/pcfd_pkg.sv
hw/rtl/pcfd_mul.sv
hw/rtl/pcfd_duty.sv
hw/rtl/pid_controller_filtered_derivative.sv
dv/tb_pid_controller_filtered_derivative.sv
